@@ hw/rtl/wqd_pkg.sv @@
// Shared package of the windowed queue delay estimator.
// Holds field widths, register indexes, reset values, the sequencer state type
// and the control structs. It depends on nothing else.
package wqd_pkg;

    localparam int WINDOW_ENTRIES = 64;
    localparam int WIN_IDX_W      = $clog2(WINDOW_ENTRIES);
    localparam int WIN_CNT_W      = $clog2(WINDOW_ENTRIES + 1);

    localparam int TIME_W   = 48;
    localparam int SVC_W    = 24;
    localparam int SQ1_W    = 2 * SVC_W;
    localparam int SUM_W    = 30;
    localparam int SQSUM_W  = 54;
    localparam int UTIL_W   = 17;
    localparam int DEN_W    = TIME_W + 1;
    localparam int CFG_AW   = 2;

    localparam logic [CFG_AW-1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_AW-1:0] REG_MAX_UTIL    = 2'd1;

    localparam logic [TIME_W-1:0] WINDOW_SIZE_RST = 48'd10000000;
    localparam logic [UTIL_W-1:0] Q16_ONE         = 17'd65536;

    // Divider: dividend bits shifted through, one per quotient bit.
    localparam int DIV_STEPS = SQSUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TENW,
        ST_EARLY,
        ST_DROP_SQ,
        ST_DROP_SUB,
        ST_CAP_HI,
        ST_CAP_LO,
        ST_DEN,
        ST_DIV1_GO,
        ST_DIV1,
        ST_MUL,
        ST_DIV2_GO,
        ST_DIV2,
        ST_EVICT_SQ,
        ST_EVICT_SUB,
        ST_INSERT
    } wqd_state_t;

    typedef struct packed {
        logic drop;
        logic insert;
    } wqd_win_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } wqd_div_stat_t;

endpackage

@@ hw/rtl/wqd_div.sv @@
// Bit-serial restoring divider, one quotient bit per clock.
// Depends on wqd_pkg for widths and the status struct.
module wqd_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [wqd_pkg::SQSUM_W-1:0]  dividend,
    input  logic [wqd_pkg::DEN_W-1:0]    divisor,
    output logic [wqd_pkg::SQSUM_W-1:0]  quotient,
    output wqd_pkg::wqd_div_stat_t       stat
);
    import wqd_pkg::*;

    logic [SQSUM_W-1:0]   work_reg, work_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [DEN_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DEN_W:0]       trial;
    logic                 ge;

    // The dividend leaves at the top of the work register while quotient bits
    // enter at the bottom.
    always_comb begin
        trial     = {rem_reg, work_reg[SQSUM_W-1]};
        ge        = trial >= {1'b0, dvs_reg};
        work_next = work_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            work_next = dividend;
            rem_next  = '0;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            work_next = {work_reg[SQSUM_W-2:0], ge};
            rem_next  = ge ? DEN_W'(trial - {1'b0, dvs_reg}) : trial[DEN_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        work_reg <= work_next;
        rem_reg  <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign quotient  = work_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ hw/rtl/wqd_window.sv @@
// Sorted row of window cells: arrival and service time per cell, fill count.
// Depends on wqd_pkg. Cells past the count hold stale data that is masked out of the comparison.
module wqd_window (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  wqd_pkg::wqd_win_ctl_t        ctl,
    input  logic [wqd_pkg::TIME_W-1:0]   new_arrival,
    input  logic [wqd_pkg::SVC_W-1:0]    new_service,
    output logic [wqd_pkg::TIME_W-1:0]   front_arrival,
    output logic [wqd_pkg::SVC_W-1:0]    front_service,
    output logic [wqd_pkg::WIN_CNT_W-1:0] count
);
    import wqd_pkg::*;

    logic [TIME_W-1:0]    arr_reg [WINDOW_ENTRIES];
    logic [SVC_W-1:0]     svc_reg [WINDOW_ENTRIES];
    logic [WIN_CNT_W-1:0] cnt_reg;
    logic                 le [WINDOW_ENTRIES];

    // A cell is "not later" when it holds an entry with arrival <= new one;
    // those cells form a prefix because the row stays sorted.
    always_comb begin
        for (int i = 0; i < WINDOW_ENTRIES; i++) begin
            le[i] = (WIN_CNT_W'(i) < cnt_reg) && (arr_reg[i] <= new_arrival);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.drop) begin
            for (int i = 0; i < WINDOW_ENTRIES - 1; i++) begin
                arr_reg[i] <= arr_reg[i+1];
                svc_reg[i] <= svc_reg[i+1];
            end
        end else if (ctl.insert) begin
            for (int i = 0; i < WINDOW_ENTRIES; i++) begin
                if (!le[i]) begin
                    if (i == 0) begin
                        arr_reg[i] <= new_arrival;
                        svc_reg[i] <= new_service;
                    end else if (le[i-1]) begin
                        arr_reg[i] <= new_arrival;
                        svc_reg[i] <= new_service;
                    end else begin
                        arr_reg[i] <= arr_reg[i-1];
                        svc_reg[i] <= svc_reg[i-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (ctl.drop) begin
            cnt_reg <= cnt_reg - 1'b1;
        end else if (ctl.insert) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign front_arrival = arr_reg[0];
    assign front_service = svc_reg[0];
    assign count         = cnt_reg;

endmodule

@@ hw/rtl/windowed_queue_delay_estimator.sv @@
// Windowed queue delay estimator, top level.
// Each transfer drops the stale entries one by one, evicts the oldest from a full window
// and runs the two 54-step bit-serial divisions when two or more entries remain and
// the denominator is nonzero. One transfer is processed at a time; the next is
// accepted the cycle after the result moves into the free output register. Reset
// (aresetn low, synchronous) empties the window, clears the sums and loads the
// register reset values.
module windowed_queue_delay_estimator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [wqd_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [wqd_pkg::TIME_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [wqd_pkg::TIME_W-1:0]    s_arrival_time,
    input  logic [wqd_pkg::SVC_W-1:0]     s_service_time,
    input  logic [wqd_pkg::TIME_W-1:0]    s_global_time,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wqd_pkg::TIME_W-1:0]    m_queue_delay,
    output logic                          m_store_overflow
);
    import wqd_pkg::*;

    wqd_state_t state_reg, state_next;

    // Configuration registers.
    logic [TIME_W-1:0] win_size_reg;
    logic [UTIL_W-1:0] max_util_reg;

    // Captured request and per-request work registers.
    logic [TIME_W-1:0]  arr_reg;
    logic [SVC_W-1:0]   svc_reg;
    logic [TIME_W-1:0]  gt_reg;
    logic [SQ1_W-1:0]   ssq_reg;
    logic [TIME_W+3:0]  tenw_reg;
    logic [TIME_W-1:0]  e1_reg;
    logic [TIME_W-1:0]  earliest_reg;
    logic [SQ1_W-1:0]   tmp_sq_reg;
    logic [UTIL_W-1:0]  cap_reg;
    logic [DEN_W-1:0]   capa_reg;
    logic [UTIL_W-1:0]  capb_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [SQSUM_W-1:0] num_reg;
    logic [TIME_W-1:0]  delay_reg;
    logic               ovf_reg;
    logic               pending_reg;

    // Running window statistics.
    logic [SUM_W-1:0]   sum_reg;
    logic [SQSUM_W-1:0] sq_reg;

    // Output register.
    logic              m_valid_reg;
    logic [TIME_W-1:0] m_delay_reg;
    logic              m_ovf_reg;

    wqd_win_ctl_t         win_ctl;
    logic [TIME_W-1:0]    front_arr;
    logic [SVC_W-1:0]     front_svc;
    logic [WIN_CNT_W-1:0] win_count;

    logic                 div_start;
    logic [SQSUM_W-1:0]   div_dividend;
    logic [DEN_W-1:0]     div_divisor;
    logic [SQSUM_W-1:0]   div_quot;
    wqd_div_stat_t        div_stat;

    // Combinational helpers of the datapath.
    logic              s_fire;
    logic              out_free;
    logic              front_old;
    logic              win_full;
    logic [TIME_W+3:0] arr_ext;
    logic [TIME_W-1:0] e2;
    logic [32:0]       cap_lo_prod;
    logic [DEN_W-1:0]  capw;
    logic [DEN_W-1:0]  busy_w;
    logic [TIME_W-1:0] idle_w;

    wqd_window u_window (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (win_ctl),
        .new_arrival   (arr_reg),
        .new_service   (svc_reg),
        .front_arrival (front_arr),
        .front_service (front_svc),
        .count         (win_count)
    );

    wqd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    assign s_ready  = (state_reg == ST_IDLE) && !pending_reg;
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // The oldest entry leaves when it falls before the earliest time of interest.
    assign front_old = (win_count != '0) && (front_arr < earliest_reg);
    assign win_full  = (win_count == WIN_CNT_W'(WINDOW_ENTRIES));

    assign arr_ext = {4'b0000, arr_reg};
    assign e2      = (arr_ext > tenw_reg) ? TIME_W'(arr_ext - tenw_reg) : '0;

    // Busy share of the window: min(sum, cap * W), with cap * W split into a
    // high and a low partial product. It never exceeds W.
    assign cap_lo_prod = win_size_reg[15:0] * cap_reg;
    assign capw        = capa_reg + {{(DEN_W-UTIL_W){1'b0}}, capb_reg};
    assign busy_w      = ({{(DEN_W-SUM_W){1'b0}}, sum_reg} < capw)
                         ? {{(DEN_W-SUM_W){1'b0}}, sum_reg} : capw;
    assign idle_w      = win_size_reg - busy_w[TIME_W-1:0];

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_fire) state_next = ST_TENW;
            ST_TENW:      state_next = ST_EARLY;
            ST_EARLY:     state_next = ST_DROP_SQ;
            ST_DROP_SQ:   state_next = front_old ? ST_DROP_SUB : ST_CAP_HI;
            ST_DROP_SUB:  state_next = ST_DROP_SQ;
            ST_CAP_HI:    state_next = ST_CAP_LO;
            ST_CAP_LO:    state_next = ST_DEN;
            ST_DEN: begin
                if (win_count <= WIN_CNT_W'(1) || idle_w == '0) begin
                    state_next = ST_EVICT_SQ;
                end else begin
                    state_next = ST_DIV1_GO;
                end
            end
            ST_DIV1_GO:   state_next = ST_DIV1;
            ST_DIV1:      if (div_stat.done) state_next = ST_MUL;
            ST_MUL:       state_next = ST_DIV2_GO;
            ST_DIV2_GO:   state_next = ST_DIV2;
            ST_DIV2:      if (div_stat.done) state_next = ST_EVICT_SQ;
            ST_EVICT_SQ:  state_next = win_full ? ST_EVICT_SUB : ST_INSERT;
            ST_EVICT_SUB: state_next = ST_INSERT;
            ST_INSERT:    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Control outputs toward the window row and the divider.
    always_comb begin
        win_ctl      = '0;
        div_start    = 1'b0;
        div_dividend = num_reg;
        div_divisor  = den_reg;
        case (state_reg)
            ST_DROP_SUB:  win_ctl.drop   = 1'b1;
            ST_EVICT_SUB: win_ctl.drop   = 1'b1;
            ST_INSERT:    win_ctl.insert = 1'b1;
            ST_DIV1_GO: begin
                div_start    = 1'b1;
                div_dividend = sq_reg;
                div_divisor  = {{(DEN_W-WIN_CNT_W){1'b0}}, win_count};
            end
            ST_DIV2_GO:   div_start = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            win_size_reg <= WINDOW_SIZE_RST;
            max_util_reg <= Q16_ONE;
            sum_reg      <= '0;
            sq_reg       <= '0;
            m_valid_reg  <= 1'b0;
            pending_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we && cfg_addr == REG_WINDOW_SIZE) begin
                win_size_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_addr == REG_MAX_UTIL) begin
                max_util_reg <= cfg_wdata[UTIL_W-1:0];
            end

            // Results park in pending until the output register is free.
            m_valid_reg <= pending_reg || (m_valid_reg && !m_ready);
            if (pending_reg && out_free) begin
                m_delay_reg <= delay_reg;
                m_ovf_reg   <= ovf_reg;
                pending_reg <= 1'b0;
            end

            case (state_reg)
                ST_DROP_SUB, ST_EVICT_SUB: begin
                    sum_reg <= sum_reg - {{(SUM_W-SVC_W){1'b0}}, front_svc};
                    sq_reg  <= sq_reg - {{(SQSUM_W-SQ1_W){1'b0}}, tmp_sq_reg};
                end
                ST_INSERT: begin
                    sum_reg     <= sum_reg + {{(SUM_W-SVC_W){1'b0}}, svc_reg};
                    sq_reg      <= sq_reg + {{(SQSUM_W-SQ1_W){1'b0}}, ssq_reg};
                    pending_reg <= 1'b1;
                end
                default: begin
                end
            endcase
        end

        // Payload registers, no reset needed.
        if (s_fire) begin
            arr_reg <= s_arrival_time;
            svc_reg <= s_service_time;
            gt_reg  <= s_global_time;
        end
        case (state_reg)
            ST_TENW: begin
                tenw_reg <= {1'b0, win_size_reg, 3'b000} + {3'b000, win_size_reg, 1'b0};
                e1_reg   <= (gt_reg > win_size_reg) ? gt_reg - win_size_reg : '0;
                ssq_reg  <= svc_reg * svc_reg;
            end
            ST_EARLY: begin
                earliest_reg <= (e1_reg > e2) ? e1_reg : e2;
            end
            ST_DROP_SQ, ST_EVICT_SQ: begin
                tmp_sq_reg <= front_svc * front_svc;
                if (state_reg == ST_EVICT_SQ) begin
                    ovf_reg <= win_full;
                end
            end
            ST_CAP_HI: begin
                cap_reg <= (max_util_reg > Q16_ONE) ? Q16_ONE : max_util_reg;
            end
            ST_CAP_LO: begin
                capa_reg <= win_size_reg[TIME_W-1:16] * cap_reg;
                capb_reg <= cap_lo_prod[32:16];
            end
            ST_DEN: begin
                den_reg <= {idle_w, 1'b0};
                if (win_count <= WIN_CNT_W'(1)) begin
                    delay_reg <= '0;
                end else if (idle_w == '0) begin
                    delay_reg <= win_size_reg;
                end
            end
            ST_MUL: begin
                num_reg <= SQSUM_W'(win_count * div_quot);
            end
            ST_DIV2: begin
                if (div_stat.done) begin
                    delay_reg <= (div_quot > {{(SQSUM_W-TIME_W){1'b0}}, win_size_reg})
                                 ? win_size_reg : div_quot[TIME_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_queue_delay    = m_delay_reg;
    assign m_store_overflow = m_ovf_reg;

    // The window never holds more entries than it has cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        win_count <= WIN_CNT_W'(WINDOW_ENTRIES))
        else $error("window count above capacity");

    // An eviction happens only from a full window.
    a_evict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVICT_SUB) |-> win_full)
        else $error("eviction from a window that is not full");

    // The divider is never restarted while a division runs.
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // An insert always leaves at least one entry behind.
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INSERT) |=> (win_count != '0))
        else $error("window empty after insert");

endmodule

@@ tb/windowed_queue_delay_estimator_test.sv @@
// Self-checking bench for the windowed queue delay estimator.
// Drives requests through the valid/ready channels, predicts each delay estimate
// with a behavioral window model and compares results in order. Depends on wqd_pkg.
module windowed_queue_delay_estimator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import wqd_pkg::*;

    localparam longint CYCLE_LIMIT = 2000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [TIME_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [TIME_W-1:0] s_arrival_time = '0;
    logic [SVC_W-1:0] s_service_time = '0;
    logic [TIME_W-1:0] s_global_time = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [TIME_W-1:0] m_queue_delay;
    logic m_store_overflow;

    always #5 aclk = ~aclk;

    windowed_queue_delay_estimator i_dut (.*);

    // A typed-in expectation marks a directed row whose result is known by inspection.
    typedef struct {
        logic [TIME_W-1:0] delay;
        logic              overflow;
    } estimate_t;

    typedef struct {
        logic [TIME_W-1:0] arrival;
        logic [SVC_W-1:0]  service;
        logic [TIME_W-1:0] global_t;
        bit                known;
        logic [TIME_W-1:0] known_delay;
    } request_t;

    // Predictor copy of the window, kept sorted by arrival time.
    logic [TIME_W-1:0] win_arrival[$];
    logic [SVC_W-1:0]  win_service[$];
    logic [63:0] sum_svc, sum_sq;
    logic [TIME_W-1:0] window_w;
    logic [UTIL_W-1:0] util_cap;

    estimate_t pending_estimates[$];
    int errors = 0;
    longint cycles = 0;
    bit hold_off = 1'b0;
    bit stall_enable = 1'b1;

    // Removes the oldest window entry and takes its values out of the sums.
    task automatic pop_oldest();
        logic [63:0] s;
        s = win_service.pop_front();
        void'(win_arrival.pop_front());
        sum_svc -= s;
        sum_sq -= s * s;
    endtask

    // Computes the delay estimate of one request and updates the window.
    task automatic predict_delay(input request_t r, output estimate_t e);
        logic [63:0] w, e1, e2, edge_t, cap, capw, busy, den, num, d;
        logic [63:0] cnt;
        int p;
        w = window_w;
        e1 = (r.global_t > w) ? r.global_t - w : 0;
        e2 = (r.arrival > 10 * w) ? r.arrival - 10 * w : 0;
        edge_t = (e1 > e2) ? e1 : e2;
        while (win_arrival.size() > 0 && win_arrival[0] < edge_t) pop_oldest();
        cnt = win_arrival.size();
        d = 0;
        if (cnt > 1) begin
            cap = (util_cap > Q16_ONE) ? Q16_ONE : util_cap;
            capw = (w >> 16) * cap + (((w & 64'hFFFF) * cap) >> 16);
            busy = (sum_svc < capw) ? sum_svc : capw;
            den = 2 * (w - busy);
            if (den == 0) begin
                d = w;
            end else begin
                num = cnt * (sum_sq / cnt);
                d = num / den;
                if (d > w) d = w;
            end
        end
        e.delay = d[TIME_W-1:0];
        e.overflow = 1'b0;
        if (win_arrival.size() >= WINDOW_ENTRIES) begin
            pop_oldest();
            e.overflow = 1'b1;
        end
        p = 0;
        while (p < win_arrival.size() && win_arrival[p] <= r.arrival) p++;
        win_arrival.insert(p, r.arrival);
        win_service.insert(p, r.service);
        sum_svc += r.service;
        sum_sq += 64'(r.service) * 64'(r.service);
    endtask

    // One register write, after which the write port is left idle before the task returns.
    task automatic write_register(input logic [CFG_AW-1:0] idx, input logic [TIME_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_WINDOW_SIZE) window_w = val;
        else if (idx == REG_MAX_UTIL) util_cap = val[UTIL_W-1:0];
        @(posedge aclk);
    endtask

    // Offers one transfer and holds it until accepted.
    task automatic send_request(input request_t r);
        estimate_t e;
        s_valid <= 1'b1;
        s_arrival_time <= r.arrival;
        s_service_time <= r.service;
        s_global_time <= r.global_t;
        do @(posedge aclk); while (!s_ready);
        predict_delay(r, e);
        if (r.known && e.delay != r.known_delay) begin
            $display("%0t directed row disagrees with predictor: expected %0d got %0d",
                     $time, r.known_delay, e.delay);
            errors++;
        end
        pending_estimates.push_back(e);
    endtask

    task automatic drain_results();
        while (pending_estimates.size() > 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    // Random request: arrivals move mostly forward in small steps so the window
    // stays populated, with occasional wild values to reach drops and extremes.
    logic [TIME_W-1:0] clock_now;
    function automatic request_t random_request();
        request_t r;
        int mode;
        mode = $urandom_range(0, 19);
        clock_now += TIME_W'($urandom_range(0, 3000));
        r.known = 1'b0;
        r.known_delay = '0;
        r.arrival = clock_now - TIME_W'($urandom_range(0, 2000));
        r.global_t = clock_now - TIME_W'($urandom_range(0, 40000));
        r.service = SVC_W'($urandom_range(0, 6000));
        if (mode == 0) r.service = SVC_W'($urandom);
        if (mode == 1) r.arrival = TIME_W'({$urandom, $urandom});
        if (mode == 2) r.global_t = TIME_W'({$urandom, $urandom});
        if (mode == 3) clock_now += TIME_W'($urandom_range(0, 200000));
        return r;
    endfunction

    // Result side: checks each transfer against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_estimates.size() == 0) begin
                $display("%0t unexpected result: expected none, actual delay %0d",
                         $time, m_queue_delay);
                errors++;
            end else begin
                estimate_t e;
                e = pending_estimates.pop_front();
                if (m_queue_delay !== e.delay) begin
                    $display("%0t queue_delay mismatch: expected %0d actual %0d",
                             $time, e.delay, m_queue_delay);
                    errors++;
                end
                if (m_store_overflow !== e.overflow) begin
                    $display("%0t store_overflow mismatch: expected %0d actual %0d",
                             $time, e.overflow, m_store_overflow);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls on its own pattern; a long hold-off lets the block back up.
    always @(posedge aclk) begin
        if (hold_off) m_ready <= 1'b0;
        else if (!stall_enable) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        int hold;
        #50000;
        hold_off = 1'b1;
        for (hold = 0; hold < 3000; hold++) @(posedge aclk);
        hold_off = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    request_t directed[$];
    initial begin
        request_t r;
        int n, burst, phase;
        window_w = WINDOW_SIZE_RST;
        util_cap = Q16_ONE;
        sum_svc = 0;
        sum_sq = 0;
        clock_now = 48'd100000;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows: empty and single-entry windows give zero, then extremes.
        r.known = 1'b1; r.known_delay = 0;
        r.arrival = 0; r.service = 0; r.global_t = 0; directed.push_back(r);
        r.arrival = 0; r.service = 24'hFFFFFF; r.global_t = 0; directed.push_back(r);
        r.known = 1'b0;
        r.arrival = 5; r.service = 24'hFFFFFF; r.global_t = 0; directed.push_back(r);
        r.arrival = 48'hFFFFFFFFFFFF; r.service = 24'hAAAAAA; r.global_t = 0;
        directed.push_back(r);
        r.arrival = 48'h555555555555; r.service = 24'h555555; r.global_t = 3;
        directed.push_back(r);
        r.arrival = 10; r.service = 1; r.global_t = 48'hFFFFFFFFFFFF; directed.push_back(r);
        r.arrival = 10; r.service = 7; r.global_t = 48'hFFFFFFFFFFFF; directed.push_back(r);
        foreach (directed[i]) send_request(directed[i]);
        s_valid <= 1'b0;
        drain_results();

        // Register sweep, covering the extremes and both unused indexes.
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin write_register(REG_WINDOW_SIZE, 0); write_register(REG_MAX_UTIL, 0); end
                1: begin write_register(REG_WINDOW_SIZE, 1); write_register(REG_MAX_UTIL, 17'h1FFFF); end
                2: begin write_register(REG_WINDOW_SIZE, 48'hFFFFFFFFFFFF); write_register(REG_MAX_UTIL, 32768); end
                3: begin write_register(REG_WINDOW_SIZE, 20000); write_register(REG_MAX_UTIL, Q16_ONE); end
                4: begin write_register(REG_WINDOW_SIZE, 5000); write_register(2'd3, 48'h1234); end
                5: begin write_register(REG_WINDOW_SIZE, 200000); write_register(REG_MAX_UTIL, 60000); end
                6: begin write_register(REG_WINDOW_SIZE, 1000000); write_register(2'd2, 7); end
                default: write_register(REG_WINDOW_SIZE, WINDOW_SIZE_RST);
            endcase
            // Equal arrivals and a zero-denominator window on the small settings.
            r.known = 1'b0; r.arrival = clock_now; r.service = 24'hFFFFFF; r.global_t = 0;
            send_request(r);
            send_request(r);
            send_request(r);
            stall_enable = (phase != 4);
            n = 0;
            while (n < 240) begin
                burst = $urandom_range(1, 30);
                repeat (burst) begin
                    send_request(random_request());
                    n++;
                end
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
            s_valid <= 1'b0;
            drain_results();
        end

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/wqd_pkg.sv
hw/rtl/wqd_div.sv
hw/rtl/wqd_window.sv
hw/rtl/windowed_queue_delay_estimator.sv
tb/windowed_queue_delay_estimator_test.sv
